// ----- rtl/core/thps_pkg.sv -----
// Shared types, constants and helpers for the three-servo position and homing block.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package thps_pkg;

    // Widths fixed by the command and result fields
    localparam int POS_W     = 8;
    localparam int MIN_W     = 9;
    localparam int OFF_W     = 5;
    localparam int KIND_W    = 2;
    localparam int SEL_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int LIFT_W    = 4;
    localparam int ARITH_W   = 12;

    localparam int SERVO_COUNT_DEF = 3;
    localparam int OUT_SERVOS      = 3;

    // Register reset values
    localparam logic [7:0] MIN_FLOOR_RST = 8'd80;
    localparam logic [7:0] MAX_POS_RST   = 8'd180;
    localparam logic [4:0] OFFSET_A_RST  = 5'sd0;
    localparam logic [4:0] OFFSET_B_RST  = 5'h1F;
    localparam logic [4:0] OFFSET_C_RST  = 5'sd5;

    // Positioning constants
    localparam logic [7:0] POS_RST      = 8'd170;
    localparam logic [7:0] HOME_PRESET  = 8'd110;
    localparam int         RELEASE_LIFT = 10;
    localparam logic [3:0] LIFT_STEPS   = 4'd9;
    localparam int         LIFT_STEP    = 5;
    localparam int         BULK_LOW_GAP = 30;
    localparam int         BULK_BIAS    = 90;
    localparam logic [7:0] DIR_UP       = 8'd1;
    localparam logic [7:0] DIR_DOWN     = 8'd0;

    typedef logic [POS_W-1:0]        t_pos;
    typedef logic [MIN_W-1:0]        t_min;
    typedef logic signed [OFF_W-1:0] t_off;
    typedef logic signed [ARITH_W-1:0] t_arith;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_START   = 3'd1,
        PH_DOWN    = 3'd2,
        PH_RELEASE = 3'd3,
        PH_UP      = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HOME = 2'd0,
        KIND_MAN  = 2'd1,
        KIND_BULK = 2'd2,
        KIND_TICK = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_MIN_FLOOR = 3'd0,
        REG_MAX_POS   = 3'd1,
        REG_OFFSET_A  = 3'd2,
        REG_OFFSET_B  = 3'd3,
        REG_OFFSET_C  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_MAN_UP,
        OP_MAN_DOWN,
        OP_BULK,
        OP_PRESET,
        OP_DESCEND,
        OP_RELEASE,
        OP_LIFT
    } t_lane_op;

    // Command broadcast from the sequencer to every lane
    typedef struct packed {
        t_lane_op op;
        t_pos     step;
        t_pos     max_pos;
        t_pos     min_floor;
    } t_lane_cmd;

    // Sequencer status seen by the top level
    typedef struct packed {
        t_phase            phase;
        logic [LIFT_W-1:0] lift;
    } t_ctrl_stat;

    // Saturate a signed intermediate to the position range
    function automatic t_pos sat_pos(input t_arith v);
        t_pos r;
        if (v < 0) begin
            r = '0;
        end else if (v > t_arith'(255)) begin
            r = '1;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/thps_lane.sv -----
// One servo lane: position, learned minimum and switch flag, updated per transfer.
// Depends on thps_pkg for the lane command and arithmetic types.
`default_nettype none

module thps_lane (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire thps_pkg::t_lane_cmd i_cmd,
    input  wire logic               i_hit,
    input  wire logic               i_bulk_en,
    input  wire thps_pkg::t_pos     i_angle,
    input  wire logic               i_switch_open,
    input  wire thps_pkg::t_off     i_offset,
    output thps_pkg::t_pos          o_pos_next,
    output logic                    o_active
);
    import thps_pkg::*;

    t_pos r_pos, n_pos;
    t_min r_min, n_min;
    logic r_seen, n_seen;

    t_arith w_pos, w_min, w_step, w_max, w_off, w_ang;
    t_arith w_sum, w_lo, w_a;

    assign w_pos  = t_arith'({1'b0, r_pos});
    assign w_min  = t_arith'({1'b0, r_min});
    assign w_step = t_arith'({1'b0, i_cmd.step});
    assign w_max  = t_arith'({1'b0, i_cmd.max_pos});
    assign w_off  = t_arith'(i_offset);
    assign w_ang  = t_arith'({1'b0, i_angle});

    // Still descending: switch not yet seen and reported open
    assign o_active = !r_seen && i_switch_open;

    // Work out the next lane state for this command
    always_comb begin
        n_pos = r_pos;
        n_min = r_min;
        n_seen = r_seen;
        w_sum = '0;
        w_lo  = '0;
        w_a   = '0;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                n_seen = 1'b0;
            end
            OP_MAN_UP: begin
                w_sum = w_pos + w_step;
                if (i_hit) begin
                    n_pos = sat_pos((w_sum > w_max) ? w_max : w_sum);
                end
            end
            OP_MAN_DOWN: begin
                w_sum = w_pos - w_step;
                if (i_hit) begin
                    n_pos = sat_pos((w_sum < w_min) ? w_min : w_sum);
                end
            end
            OP_BULK: begin
                w_lo = w_min + t_arith'(BULK_LOW_GAP);
                if (w_ang < w_lo) begin
                    w_a = w_lo;
                end else if (w_ang > w_max) begin
                    w_a = w_max;
                end else begin
                    w_a = w_ang;
                end
                w_sum = w_a + w_min - t_arith'(BULK_BIAS);
                if (i_bulk_en) begin
                    n_pos = sat_pos(w_sum);
                end
            end
            OP_PRESET: begin
                n_pos = HOME_PRESET;
                n_min = t_min'(i_cmd.min_floor);
            end
            OP_DESCEND: begin
                if (!r_seen) begin
                    if (i_switch_open) begin
                        w_sum = w_pos - t_arith'(1);
                        n_pos = sat_pos((w_sum < (w_min - w_off)) ? w_min : w_sum);
                    end else begin
                        // Learn the minimum where the switch closed
                        w_sum = w_pos + w_off;
                        n_min = (w_sum < 0) ? '0 : w_sum[MIN_W-1:0];
                        n_seen = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                w_sum = w_min + t_arith'(RELEASE_LIFT);
                if (r_seen) begin
                    n_pos = sat_pos((w_sum > w_max) ? w_max : w_sum);
                end
            end
            OP_LIFT: begin
                w_sum = w_pos + t_arith'(LIFT_STEP);
                n_pos = sat_pos((w_sum > w_max) ? w_max : w_sum);
            end
            default: begin
            end
        endcase
    end

    assign o_pos_next = n_pos;

    // Commit on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_RST;
            r_min  <= t_min'(MIN_FLOOR_RST);
            r_seen <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_min  <= n_min;
            r_seen <= n_seen;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/thps_ctrl.sv -----
// Command decode and homing sequencer; merges the lanes' descent flags.
// Depends on thps_pkg for phase, kind and lane command types.
`default_nettype none

module thps_ctrl #(
    parameter int SERVO_COUNT = thps_pkg::SERVO_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_accept,
    input  wire logic [thps_pkg::KIND_W-1:0] i_kind,
    input  wire thps_pkg::t_pos              i_direction_code,
    input  wire thps_pkg::t_pos              i_step_size,
    input  wire thps_pkg::t_pos              i_max_pos,
    input  wire thps_pkg::t_pos              i_min_floor,
    input  wire logic [SERVO_COUNT-1:0]      i_active,
    output thps_pkg::t_lane_cmd              o_cmd,
    output thps_pkg::t_phase                 o_phase_next,
    output thps_pkg::t_ctrl_stat             o_stat
);
    import thps_pkg::*;

    t_phase            r_phase, n_phase;
    logic [LIFT_W-1:0] r_lift, n_lift;
    t_kind             w_kind;
    logic              w_all_closed;
    logic              w_lifting;

    assign w_kind       = t_kind'(i_kind);
    assign w_all_closed = (i_active == '0);
    assign w_lifting    = (r_lift < LIFT_STEPS);

    // Next phase and lift count
    always_comb begin
        n_phase = r_phase;
        n_lift  = r_lift;
        unique case (w_kind)
            KIND_HOME: begin
                n_phase = PH_START;
                n_lift  = '0;
            end
            KIND_TICK: begin
                unique case (r_phase)
                    PH_IDLE:    n_phase = PH_IDLE;
                    PH_START:   n_phase = PH_DOWN;
                    PH_DOWN:    n_phase = w_all_closed ? PH_RELEASE : PH_DOWN;
                    PH_RELEASE: begin
                        n_phase = PH_UP;
                        n_lift  = '0;
                    end
                    PH_UP: begin
                        if (w_lifting) begin
                            n_lift = r_lift + 1'b1;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default:    n_phase = PH_IDLE;
                endcase
            end
            default: begin
            end
        endcase
    end

    // Lane command for this transfer
    always_comb begin
        o_cmd.step      = i_step_size;
        o_cmd.max_pos   = i_max_pos;
        o_cmd.min_floor = i_min_floor;
        o_cmd.op        = OP_NONE;
        unique case (w_kind)
            KIND_HOME: o_cmd.op = OP_CLEAR;
            KIND_MAN: begin
                if (i_direction_code == DIR_UP) begin
                    o_cmd.op = OP_MAN_UP;
                end else if (i_direction_code == DIR_DOWN) begin
                    o_cmd.op = OP_MAN_DOWN;
                end
            end
            KIND_BULK: o_cmd.op = OP_BULK;
            KIND_TICK: begin
                unique case (r_phase)
                    PH_START:   o_cmd.op = OP_PRESET;
                    PH_DOWN:    o_cmd.op = OP_DESCEND;
                    PH_RELEASE: o_cmd.op = OP_RELEASE;
                    PH_UP:      o_cmd.op = w_lifting ? OP_LIFT : OP_NONE;
                    default:    o_cmd.op = OP_NONE;
                endcase
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_phase_next = n_phase;
    assign o_stat.phase = r_phase;
    assign o_stat.lift  = r_lift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lift  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_lift  <= n_lift;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/three_servo_position_homing_top.sv -----
// Top level: configuration registers, servo lanes, sequencer and result register.
// Depends on thps_pkg, thps_lane and thps_ctrl.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   kind, servo_sel, direction_code, step_size,
//                                                angle_a..c, switch_open
//  out      source     o_out_valid / i_out_stall pos_a..c, homing_phase
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One command per cycle: each transfer updates every lane and the sequencer in the
// cycle it is taken, and its result appears in the output register on the next cycle.
// Throughput is set by the single output register: the input stalls only while a result
// is held and the sink stalls. Reset is synchronous, active low, and restores positions
// to 170, minimums to the floor reset and the phase to idle. Configuration is always ready.
`default_nettype none

module three_servo_position_homing_top #(
    parameter int SERVO_COUNT = thps_pkg::SERVO_COUNT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [thps_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [thps_pkg::SEL_W-1:0]     i_servo_sel,
    input  wire logic [7:0]                     i_direction_code,
    input  wire logic [7:0]                     i_step_size,
    input  wire logic [7:0]                     i_angle_a,
    input  wire logic [7:0]                     i_angle_b,
    input  wire logic [7:0]                     i_angle_c,
    input  wire logic [2:0]                     i_switch_open,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_pos_a,
    output logic [7:0]                          o_pos_b,
    output logic [7:0]                          o_pos_c,
    output logic [2:0]                          o_homing_phase,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [thps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [thps_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import thps_pkg::*;

    t_pos r_min_floor, r_max_pos;
    t_off r_offset [OUT_SERVOS];

    logic       w_accept;
    t_lane_cmd  w_cmd;
    t_phase     w_phase_next;
    t_ctrl_stat w_stat;
    logic [SERVO_COUNT-1:0] w_active;
    t_pos w_pos_next [SERVO_COUNT];
    t_pos w_out      [OUT_SERVOS];
    t_pos w_angle    [OUT_SERVOS];

    logic   r_out_valid;
    t_pos   r_pos_a, r_pos_b, r_pos_c;
    t_phase r_phase;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_angle[0] = i_angle_a;
    assign w_angle[1] = i_angle_b;
    assign w_angle[2] = i_angle_c;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_floor <= MIN_FLOOR_RST;
            r_max_pos   <= MAX_POS_RST;
            r_offset[0] <= OFFSET_A_RST;
            r_offset[1] <= OFFSET_B_RST;
            r_offset[2] <= OFFSET_C_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MIN_FLOOR: r_min_floor <= i_cfg_data;
                REG_MAX_POS:   r_max_pos   <= i_cfg_data;
                REG_OFFSET_A:  r_offset[0] <= i_cfg_data[OFF_W-1:0];
                REG_OFFSET_B:  r_offset[1] <= i_cfg_data[OFF_W-1:0];
                REG_OFFSET_C:  r_offset[2] <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    thps_ctrl #(
        .SERVO_COUNT (SERVO_COUNT)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_kind           (i_kind),
        .i_direction_code (i_direction_code),
        .i_step_size      (i_step_size),
        .i_max_pos        (r_max_pos),
        .i_min_floor      (r_min_floor),
        .i_active         (w_active),
        .o_cmd            (w_cmd),
        .o_phase_next     (w_phase_next),
        .o_stat           (w_stat)
    );

    // One lane per servo; servos past the third have no angle, offset or switch
    for (genvar g = 0; g < SERVO_COUNT; g++) begin : g_lane
        logic w_hit;
        assign w_hit = (int'(i_servo_sel) == g);
        if (g < OUT_SERVOS) begin : g_wired
            thps_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_accept      (w_accept),
                .i_cmd         (w_cmd),
                .i_hit         (w_hit),
                .i_bulk_en     (1'b1),
                .i_angle       (w_angle[g]),
                .i_switch_open (i_switch_open[g]),
                .i_offset      (r_offset[g]),
                .o_pos_next    (w_pos_next[g]),
                .o_active      (w_active[g])
            );
        end else begin : g_extra
            thps_lane u_lane (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_accept      (w_accept),
                .i_cmd         (w_cmd),
                .i_hit         (w_hit),
                .i_bulk_en     (1'b0),
                .i_angle       ('0),
                .i_switch_open (1'b0),
                .i_offset      ('0),
                .o_pos_next    (w_pos_next[g]),
                .o_active      (w_active[g])
            );
        end
    end

    // Result fields; absent servos read zero
    for (genvar g = 0; g < OUT_SERVOS; g++) begin : g_out
        if (g < SERVO_COUNT) begin : g_have
            assign w_out[g] = w_pos_next[g];
        end else begin : g_none
            assign w_out[g] = '0;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos_a <= w_out[0];
            r_pos_b <= w_out[1];
            r_pos_c <= w_out[2];
            r_phase <= w_phase_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_a        = r_pos_a;
    assign o_pos_b        = r_pos_b;
    assign o_pos_c        = r_pos_c;
    assign o_homing_phase = r_phase;

    // A transfer always leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("transfer did not produce a result");

    // The phase shown matches the sequencer while a result is held
    a_phase_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_homing_phase == w_stat.phase))
        else $error("result phase differs from sequencer phase");

    // A homing command always arms the sequence
    a_home_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_kind'(i_kind) == KIND_HOME)) |=> (w_stat.phase == PH_START))
        else $error("homing command did not arm the sequence");

    // The lift counter never passes the number of lifts
    a_lift_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.lift <= LIFT_STEPS)
        else $error("lift count out of range");

endmodule

`default_nettype wire
